/* rtl/core/abf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package abf_pkg;

  localparam int UNIT_BITS   = 30;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_QW      = 33;
  // front end 8, square root, divide, back end 8
  localparam int LATENCY     = 8 + SQRT_STEPS + DIV_QW + 8;
  localparam logic [30:0] GAIN_MAX = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    REG_ANGLE_K = 3'd0,
    REG_BOX_X   = 3'd1,
    REG_BOX_Y   = 3'd2,
    REG_BOX_Z   = 3'd3,
    REG_PMASK   = 3'd4
  } cfg_reg_e;

  // side data riding along the square root
  typedef struct packed {
    logic [1:0][2:0][29:0] mg;
    logic [1:0][2:0]       sgn;
    logic [1:0][61:0]      gnum;
    logic [1:0]            gsat;
    logic                  degen;
  } root_sb_t;

  // side data riding along the dividers
  typedef struct packed {
    logic [1:0][2:0] sgn;
    logic [1:0]      gsat;
    logic            degen;
  } div_sb_t;

  // shift right by the unit width, truncating toward zero
  function automatic logic signed [67:0] shr30(input logic signed [67:0] v);
    logic signed [67:0] bias;
    bias = v[67] ? 68'sd1073741823 : 68'sd0;
    return (v + bias) >>> UNIT_BITS;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sh00_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -40'sh00_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/abf_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage. Needs num < den << Q_W.
module abf_div #(
  parameter int NUM_W = 62,
  parameter int DEN_W = 31,
  parameter int Q_W   = 33
) (
  input  wire logic             clk,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [Q_W-1:0]   q
);

  localparam int W = DEN_W + Q_W;

  logic [W-1:0]     rem_s [Q_W];
  logic [DEN_W-1:0] den_s [Q_W];
  logic [Q_W-1:0]   q_s   [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int B = Q_W - 1 - i;
    logic [W-1:0]     rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [W-1:0]     shd;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = W'(num);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_s[i-1];
      assign den_in = den_s[i-1];
      assign q_in   = q_s[i-1];
    end

    assign shd = W'(den_in) << B;
    assign ge  = rem_in >= shd;

    always_ff @(posedge clk) begin
      rem_s[i] <= ge ? rem_in - shd : rem_in;
      den_s[i] <= den_in;
      q_s[i]   <= {q_in[Q_W-2:0], ge};
    end
  end

  assign q = q_s[Q_W-1];

endmodule
`default_nettype wire

/* rtl/core/angle_bond_force_3d_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                 Word
// -------   ---------------------     ---------------------------------------
// input     start, busy               first/middle/third _x/_y/_z positions
// result    done (one-cycle strobe)   force_first/middle/third _x/_y/_z, degenerate
// config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// One triplet accepted per cycle; busy is high and cfg_ready low only during reset.
// Each result passes through 8 front-end stages, 32 square-root steps,
// 33 divider stages (one quotient bit each) and 8 back-end stages.
// Synchronous reset clears the valid line and the config registers to their reset values.
// The pipeline never stalls: the receiver takes every word on the done cycle.
module angle_bond_force_3d_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic signed [31:0] first_x,
  input  wire logic signed [31:0] first_y,
  input  wire logic signed [31:0] first_z,
  input  wire logic signed [31:0] middle_x,
  input  wire logic signed [31:0] middle_y,
  input  wire logic signed [31:0] middle_z,
  input  wire logic signed [31:0] third_x,
  input  wire logic signed [31:0] third_y,
  input  wire logic signed [31:0] third_z,
  output logic                    done,
  output logic signed [31:0]      force_first_x,
  output logic signed [31:0]      force_first_y,
  output logic signed [31:0]      force_first_z,
  output logic signed [31:0]      force_middle_x,
  output logic signed [31:0]      force_middle_y,
  output logic signed [31:0]      force_middle_z,
  output logic signed [31:0]      force_third_x,
  output logic signed [31:0]      force_third_y,
  output logic signed [31:0]      force_third_z,
  output logic                    degenerate
);
  import abf_pkg::*;

  // config registers
  logic [31:0] angle_constant;
  logic [30:0] box_width [3];
  logic [2:0]  periodic_mask;

  // nothing is taken while reset is held
  assign cfg_ready = !rst;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_constant <= 32'd65536;
      box_width[0]   <= '0;
      box_width[1]   <= '0;
      box_width[2]   <= '0;
      periodic_mask  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ANGLE_K: angle_constant <= cfg_data;
        REG_BOX_X:   box_width[0]   <= cfg_data[30:0];
        REG_BOX_Y:   box_width[1]   <= cfg_data[30:0];
        REG_BOX_Z:   box_width[2]   <= cfg_data[30:0];
        REG_PMASK:   periodic_mask  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // valid bits travel alongside the data
  logic [LATENCY-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[LATENCY-2:0], accept};
  end

  function automatic logic [4:0] lead_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  logic signed [31:0] pf [3], pm [3], pt [3];
  assign pf[0] = first_x;  assign pf[1] = first_y;  assign pf[2] = first_z;
  assign pm[0] = middle_x; assign pm[1] = middle_y; assign pm[2] = middle_z;
  assign pt[0] = third_x;  assign pt[1] = third_y;  assign pt[2] = third_z;

  // stage 1: bond differences from the middle atom
  logic signed [33:0] d1 [2][3];
  // stage 2: minimum image
  logic signed [33:0] d2 [2][3];
  // stage 3: magnitudes
  logic [31:0] mag3 [2][3];
  logic [1:0][2:0] sgn3;
  // stage 4: largest magnitude
  logic [31:0] mag4 [2][3];
  logic [31:0] max4 [2];
  logic [1:0][2:0] sgn4;
  // stage 5: scale exponent
  logic [31:0] mag5 [2][3];
  logic signed [5:0] e5 [2];
  logic [1:0][2:0] sgn5;
  logic degen5;
  // stage 6: scaled components, gain numerators
  root_sb_t sb6;
  // stages 7, 8: squares and sum
  logic [59:0] sq7 [2][3];
  logic [61:0] sum8 [2];

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      d1[0][a] <= 34'(pf[a]) - 34'(pm[a]);
      d1[1][a] <= 34'(pt[a]) - 34'(pm[a]);
    end
    for (int b = 0; b < 2; b++) begin
      for (int a = 0; a < 3; a++) begin
        logic [33:0] m2;
        m2 = d1[b][a][33] ? 34'(-d1[b][a]) : 34'(d1[b][a]);
        if (periodic_mask[a] && ((m2 << 1) > 34'(box_width[a]))) begin
          d2[b][a] <= d1[b][a][33] ? d1[b][a] + 34'(box_width[a])
                                   : d1[b][a] - 34'(box_width[a]);
        end else begin
          d2[b][a] <= d1[b][a];
        end
      end
    end
    for (int b = 0; b < 2; b++) begin
      for (int a = 0; a < 3; a++) begin
        logic [33:0] m3;
        m3 = d2[b][a][33] ? 34'(-d2[b][a]) : 34'(d2[b][a]);
        mag3[b][a] <= m3[31:0];
        sgn3[b][a] <= d2[b][a][33];
      end
    end
    for (int b = 0; b < 2; b++) begin
      logic [31:0] mx;
      mx = mag3[b][0];
      if (mag3[b][1] > mx) mx = mag3[b][1];
      if (mag3[b][2] > mx) mx = mag3[b][2];
      max4[b] <= mx;
      mag4[b] <= mag3[b];
    end
    sgn4 <= sgn3;
    // stage 5: place the top bit of the largest component at bit 29
    for (int b = 0; b < 2; b++) begin
      e5[b]   <= 6'sd29 - $signed({1'b0, lead_pos(max4[b])});
      mag5[b] <= mag4[b];
    end
    sgn5   <= sgn4;
    degen5 <= (max4[0] == '0) || (max4[1] == '0);
    // stage 6
    for (int b = 0; b < 2; b++) begin
      logic [61:0] ext;
      logic [6:0]  t;
      logic [93:0] wide;
      for (int a = 0; a < 3; a++) begin
        ext = {30'b0, mag5[b][a]};
        ext = e5[b][5] ? (ext >> 6'(-e5[b])) : (ext << 6'(e5[b]));
        sb6.mg[b][a] <= ext[29:0];
      end
      t    = 7'(FRAC_BITS) + 7'(e5[b]);
      wide = {62'b0, angle_constant} << t;
      sb6.gsat[b] <= |wide[93:62];
      sb6.gnum[b] <= wide[61:0];
    end
    sb6.sgn   <= sgn5;
    sb6.degen <= degen5;
    // stages 7, 8
    for (int b = 0; b < 2; b++) begin
      for (int a = 0; a < 3; a++) begin
        sq7[b][a] <= sb6.mg[b][a] * sb6.mg[b][a];
      end
      sum8[b] <= 62'(sq7[b][0]) + 62'(sq7[b][1]) + 62'(sq7[b][2]);
    end
  end

  // square root, one result bit per stage
  logic [63:0] sq_v [2][SQRT_STEPS];
  logic [63:0] sq_r [2][SQRT_STEPS];

  for (genvar b = 0; b < 2; b++) begin : g_root
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
      logic [63:0] v_in, r_in, trial;
      if (j == 0) begin : g_first
        assign v_in = 64'(sum8[b]);
        assign r_in = '0;
      end else begin : g_next
        assign v_in = sq_v[b][j-1];
        assign r_in = sq_r[b][j-1];
      end
      assign trial = r_in + BIT;
      always_ff @(posedge clk) begin
        if (v_in >= trial) begin
          sq_v[b][j] <= v_in - trial;
          sq_r[b][j] <= (r_in >> 1) + BIT;
        end else begin
          sq_v[b][j] <= v_in;
          sq_r[b][j] <= r_in >> 1;
        end
      end
    end
  end

  logic [30:0] norm [2];
  assign norm[0] = sq_r[0][SQRT_STEPS-1][30:0];
  assign norm[1] = sq_r[1][SQRT_STEPS-1][30:0];

  // side data delayed to line up with the norms
  root_sb_t sbd [SQRT_STEPS+2];
  div_sb_t  dbd [DIV_QW];
  always_ff @(posedge clk) begin
    sbd[0] <= sb6;
    for (int i = 1; i < SQRT_STEPS + 2; i++) sbd[i] <= sbd[i-1];
    dbd[0].sgn   <= sbd[SQRT_STEPS+1].sgn;
    dbd[0].gsat  <= sbd[SQRT_STEPS+1].gsat;
    dbd[0].degen <= sbd[SQRT_STEPS+1].degen;
    for (int i = 1; i < DIV_QW; i++) dbd[i] <= dbd[i-1];
  end

  // unit vector and gain dividers
  logic [DIV_QW-1:0] uq [2][3];
  logic [DIV_QW-1:0] gq [2];

  for (genvar b = 0; b < 2; b++) begin : g_div
    for (genvar a = 0; a < 3; a++) begin : g_axis
      abf_div #(.NUM_W(62), .DEN_W(31), .Q_W(DIV_QW)) u_unit (
        .clk (clk),
        .num ({2'b0, sbd[SQRT_STEPS+1].mg[b][a], 30'b0}),
        .den (norm[b]),
        .q   (uq[b][a])
      );
    end
    abf_div #(.NUM_W(62), .DEN_W(31), .Q_W(DIV_QW)) u_gain (
      .clk (clk),
      .num (sbd[SQRT_STEPS+1].gnum[b]),
      .den (norm[b]),
      .q   (gq[b])
    );
  end

  // back end
  logic signed [31:0] u74 [2][3], u75 [2][3], u76 [2][3];
  logic [30:0]        g74 [2], g75 [2], g76 [2], g77 [2], g78 [2];
  logic [6:0]         dg;    // degenerate flag, stages 74..80
  logic signed [63:0] dot75 [3];
  logic signed [33:0] cs76;
  logic signed [65:0] cu77 [2][3];
  logic signed [33:0] w78 [2][3];
  logic signed [65:0] gw79 [2][3];
  logic signed [35:0] f80 [2][3];
  logic signed [31:0] u77 [2][3];

  always_ff @(posedge clk) begin
    div_sb_t s;
    logic signed [67:0] dsum;
    s = dbd[DIV_QW-1];
    for (int b = 0; b < 2; b++) begin
      for (int a = 0; a < 3; a++) begin
        u74[b][a] <= s.sgn[b][a] ? -$signed(uq[b][a][31:0]) : $signed(uq[b][a][31:0]);
      end
      g74[b] <= (s.gsat[b] || gq[b] > DIV_QW'(GAIN_MAX)) ? GAIN_MAX : gq[b][30:0];
    end
    dg[0] <= s.degen;
    for (int i = 1; i < 7; i++) dg[i] <= dg[i-1];
    // cosine
    for (int a = 0; a < 3; a++) dot75[a] <= u74[0][a] * u74[1][a];
    u75 <= u74;
    g75 <= g74;
    dsum = 68'(dot75[0]) + 68'(dot75[1]) + 68'(dot75[2]);
    cs76 <= 34'(shr30(dsum));
    u76  <= u75;
    g76  <= g75;
    // c * u
    for (int b = 0; b < 2; b++) begin
      for (int a = 0; a < 3; a++) cu77[b][a] <= cs76 * u76[b][a];
    end
    u77 <= u76;
    g77 <= g76;
    for (int a = 0; a < 3; a++) begin
      w78[0][a] <= 34'(shr30(68'(cu77[0][a]))) - 34'(u77[1][a]);
      w78[1][a] <= 34'(shr30(68'(cu77[1][a]))) - 34'(u77[0][a]);
    end
    g78 <= g77;
    for (int b = 0; b < 2; b++) begin
      for (int a = 0; a < 3; a++) begin
        gw79[b][a] <= $signed({1'b0, g78[b]}) * w78[b][a];
      end
    end
    for (int b = 0; b < 2; b++) begin
      for (int a = 0; a < 3; a++) f80[b][a] <= 36'(shr30(68'(gw79[b][a])));
    end
  end

  // output register; middle force from unsaturated outer forces
  logic signed [31:0] ff [3], fmid [3], ft [3];
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (dg[6]) begin
        ff[a]   <= '0;
        fmid[a] <= '0;
        ft[a]   <= '0;
      end else begin
        ff[a]   <= sat32(40'(f80[0][a]));
        ft[a]   <= sat32(40'(f80[1][a]));
        fmid[a] <= sat32(-(40'(f80[0][a]) + 40'(f80[1][a])));
      end
    end
    degenerate <= dg[6];
  end

  assign done           = vld[LATENCY-1];
  assign force_first_x  = ff[0];
  assign force_first_y  = ff[1];
  assign force_first_z  = ff[2];
  assign force_middle_x = fmid[0];
  assign force_middle_y = fmid[1];
  assign force_middle_z = fmid[2];
  assign force_third_x  = ft[0];
  assign force_third_y  = ft[1];
  assign force_third_z  = ft[2];

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result word without matching input word");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (force_first_x == 0 && force_middle_y == 0 && force_third_z == 0))
    else $error("degenerate word with nonzero force");

  a_cfg_k: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == REG_ANGLE_K) |=> angle_constant == $past(cfg_data))
    else $error("stiffness write lost");
`endif

endmodule
`default_nettype wire
